// File: hdl/ssmc_pkg.sv
package ssmc_pkg;

   // Sizing
   localparam int MAX_DIGITS_DEFAULT = 8;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGIT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_ZEROS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_POS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_ENABLE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_INTVL  = 3'd5;

   // Command codes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_NUMBER = 3'd1;
   localparam logic [2:0] MODE_CHAR   = 3'd2;
   localparam logic [2:0] MODE_ERROR  = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   // Display constants
   localparam logic [3:0] PWM_LAST     = 4'd9;
   localparam logic [6:0] FULL_BRIGHT  = 7'd100;
   localparam logic [7:0] POINT_BIT    = 8'h80;
   localparam logic [7:0] PAT_E        = 8'h79;
   localparam logic [7:0] PAT_R        = 8'h50;
   localparam logic [7:0] PAT_BLANK    = 8'h00;
   // ceil(2^35 / 10): v / 10 == (v * DIV10_RECIP) >> 35 for every 32-bit v
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] number_value;
      logic [7:0]  char_code;
      logic [2:0]  char_position;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] segment_lines;
      logic [7:0] digit_select;
      logic       digit_lit;
   } rsp_type;

   function automatic logic [7:0] dec_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5B;
         4'd3: pat = 8'h4F;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6D;
         4'd6: pat = 8'h7D;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h6F;
         default: pat = PAT_BLANK;
      endcase
      return pat;
   endfunction

   function automatic logic [7:0] char_pattern(input logic [7:0] code);
      logic [7:0] pat;
      if (code >= 8'h30 && code <= 8'h39) begin
         pat = dec_pattern(4'(code - 8'h30));
      end else begin
         unique case (code)
            8'h48: pat = 8'h76; // H
            8'h45: pat = 8'h79; // E
            8'h4C: pat = 8'h38; // L
            8'h50: pat = 8'h73; // P
            8'h4F: pat = 8'h3F; // O
            8'h41: pat = 8'h77; // A
            8'h43: pat = 8'h39; // C
            8'h55: pat = 8'h3E; // U
            8'h53: pat = 8'h6D; // S
            8'h74: pat = 8'h78; // t
            8'h72: pat = 8'h50; // r
            8'h62: pat = 8'h7C; // b
            8'h49: pat = 8'h06; // I
            8'h6E: pat = 8'h54; // n
            8'h64: pat = 8'h5E; // d
            8'h2D: pat = 8'h40; // -
            default: pat = PAT_BLANK;
         endcase
      end
      return pat;
   endfunction

endpackage

// File: hdl/seven_segment_mux_controller.sv
// Channel  Direction  Payload               Transfer when
// req      in         ssmc_pkg::req_type    req_valid & req_ready
// rsp      out        ssmc_pkg::rsp_type    rsp_valid & rsp_ready
// csr      in         index + 16-bit data   csr_we
//
// One command at a time; a refresh tick, char write or unused code goes straight to the done step.
// Write number steps through one divide-by-ten multiply and one pattern-store write
// per digit (N digits in use). Clear and error sweep one write per digit.
// Reset is synchronous and clears the pattern store through per-entry valid bits.
// A stalled result waits in the output register while the next command is taken.
module seven_segment_mux_controller #(
   parameter int MAX_DIGITS = ssmc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ssmc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ssmc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [ssmc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssmc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_WRITE,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type            state_ff;

   // Configuration
   logic [3:0]           digit_count_ff;
   logic [6:0]           brightness_ff;
   logic                 lead_zeros_ff;
   logic [3:0]           point_pos_ff;
   logic                 disp_enable_ff;
   logic [15:0]          flash_intvl_ff;

   // Scan and flash state
   logic [IDX_W-1:0]     scan_ff;
   logic [3:0]           pwm_ff;
   logic                 visible_ff;
   logic [31:0]          flash_ref_ff;
   logic [7:0]           latch_ff;

   // Command state
   logic [2:0]           op_ff;
   logic [31:0]          val_ff;
   logic [28:0]          quot_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 lit_ff;
   logic [7:0]           sel_ff;

   // Pattern store
   logic [7:0]           store_ff [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] valid_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;

   logic                 rsp_valid_ff;
   ssmc_pkg::rsp_type    rsp_data_ff;

   logic                 req_fire;
   logic [CNT_W-1:0]     n_c;
   logic [IDX_W-1:0]     scan_adj_c;
   logic [IDX_W-1:0]     scan_next_c;
   logic [7:0]           sel_c;
   logic [31:0]          elapsed_c;
   logic                 visible_in;
   logic [31:0]          flash_ref_in;
   logic [6:0]           pwm_step_c;
   logic                 lit_c;
   logic                 pos_ok_c;
   logic [63:0]          prod_c;
   logic [3:0]           rem_c;
   logic [7:0]           num_pat_c;
   logic [7:0]           sweep_pat_c;
   logic                 we_c;
   logic [IDX_W-1:0]     wa_c;
   logic [7:0]           wd_c;
   logic [7:0]           latch_in;
   logic [6:0]           bright_wr_c;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the digit count to 1..MAX_DIGITS
   always_comb begin
      if (digit_count_ff == 4'd0) begin
         n_c = CNT_W'(1);
      end else if (32'(digit_count_ff) > 32'(MAX_DIGITS)) begin
         n_c = CNT_W'(MAX_DIGITS);
      end else begin
         n_c = CNT_W'(digit_count_ff);
      end
   end

   // Scan position: restart at digit 0 when the count shrank below it
   assign scan_adj_c  = (CNT_W'(scan_ff) >= n_c) ? '0 : scan_ff;
   assign scan_next_c = (CNT_W'(scan_adj_c) + CNT_W'(1) == n_c) ? '0
                                                                : scan_adj_c + IDX_W'(1);

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         sel_c[j] = (32'(scan_adj_c) == j);
      end
   end

   // Flash toggle; interval zero re-arms the reference
   assign elapsed_c = req_data.now_ms - flash_ref_ff;
   always_comb begin
      visible_in   = visible_ff;
      flash_ref_in = flash_ref_ff;
      if (flash_intvl_ff == 16'd0) begin
         visible_in   = 1'b1;
         flash_ref_in = req_data.now_ms;
      end else if (elapsed_c >= 32'(flash_intvl_ff)) begin
         visible_in   = !visible_ff;
         flash_ref_in = req_data.now_ms;
      end
   end

   // Lit while pwm_phase < brightness/10, i.e. (phase+1)*10 <= brightness
   assign pwm_step_c = 7'(pwm_ff) + 7'd1;
   assign lit_c = disp_enable_ff && visible_in
                  && (7'((pwm_step_c << 3) + (pwm_step_c << 1)) <= brightness_ff);

   assign pos_ok_c = CMP_W'(req_data.char_position) < CMP_W'(n_c);

   // Divide by ten: reciprocal multiply, then remainder by shift-add
   assign prod_c = 64'(val_ff) * 64'(ssmc_pkg::DIV10_RECIP);
   assign rem_c  = 4'(val_ff - ((32'(quot_ff) << 3) + (32'(quot_ff) << 1)));

   always_comb begin
      if (val_ff == 32'd0 && CNT_W'(idx_ff) + CNT_W'(1) < n_c && !lead_zeros_ff) begin
         num_pat_c = ssmc_pkg::PAT_BLANK;
      end else begin
         num_pat_c = ssmc_pkg::dec_pattern(rem_c);
      end
      if (CMP_W'(point_pos_ff) == CMP_W'(n_c) - CMP_W'(idx_ff)) begin
         num_pat_c = num_pat_c | ssmc_pkg::POINT_BIT;
      end
   end

   // Error text in the three leftmost digits, blank elsewhere
   always_comb begin
      sweep_pat_c = ssmc_pkg::PAT_BLANK;
      if (op_ff == ssmc_pkg::MODE_ERROR && n_c >= CNT_W'(3)) begin
         if (idx_ff == IDX_W'(0)) begin
            sweep_pat_c = ssmc_pkg::PAT_E;
         end else if (idx_ff == IDX_W'(1) || idx_ff == IDX_W'(2)) begin
            sweep_pat_c = ssmc_pkg::PAT_R;
         end
      end
   end

   // Store write port
   always_comb begin
      we_c = 1'b0;
      wa_c = idx_ff;
      wd_c = sweep_pat_c;
      unique case (state_ff)
         S_IDLE: begin
            we_c = req_fire && req_data.mode == ssmc_pkg::MODE_CHAR && pos_ok_c;
            wa_c = IDX_W'(req_data.char_position);
            wd_c = ssmc_pkg::char_pattern(req_data.char_code);
         end
         S_WRITE: begin
            we_c = 1'b1;
            wd_c = num_pat_c;
         end
         S_SWEEP: begin
            we_c = 1'b1;
         end
         S_DIV, S_DONE: begin
            we_c = 1'b0;
         end
         default: begin
            we_c = 1'b0;
         end
      endcase
   end

   // Pattern store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we_c) begin
         store_ff[wa_c] <= wd_c;
      end
      if (req_fire) begin
         rd_data_ff  <= store_ff[scan_adj_c];
         rd_valid_ff <= valid_ff[scan_adj_c];
      end
   end

   // Latch update on a lit tick; never-written entries read blank
   always_comb begin
      latch_in = latch_ff;
      if (op_ff == ssmc_pkg::MODE_TICK && lit_ff) begin
         latch_in = rd_valid_ff ? rd_data_ff : ssmc_pkg::PAT_BLANK;
      end
   end

   assign bright_wr_c = (csr_wdata[6:0] > ssmc_pkg::FULL_BRIGHT) ? ssmc_pkg::FULL_BRIGHT
                                                                 : csr_wdata[6:0];

   // Control, configuration and sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         scan_ff        <= '0;
         pwm_ff         <= 4'd0;
         visible_ff     <= 1'b1;
         flash_ref_ff   <= 32'd0;
         latch_ff       <= ssmc_pkg::PAT_BLANK;
         valid_ff       <= '0;
         digit_count_ff <= 4'd4;
         brightness_ff  <= ssmc_pkg::FULL_BRIGHT;
         lead_zeros_ff  <= 1'b0;
         point_pos_ff   <= 4'd0;
         disp_enable_ff <= 1'b1;
         flash_intvl_ff <= 16'd0;
      end else begin
         // Configuration writes
         if (csr_we) begin
            unique case (csr_index)
               ssmc_pkg::CSR_DIGIT_COUNT: digit_count_ff <= csr_wdata[3:0];
               ssmc_pkg::CSR_BRIGHTNESS:  brightness_ff  <= bright_wr_c;
               ssmc_pkg::CSR_LEAD_ZEROS:  lead_zeros_ff  <= csr_wdata[0];
               ssmc_pkg::CSR_POINT_POS:   point_pos_ff   <= csr_wdata[3:0];
               ssmc_pkg::CSR_DISP_ENABLE: disp_enable_ff <= csr_wdata[0];
               ssmc_pkg::CSR_FLASH_INTVL: flash_intvl_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Mark written entries
         if (we_c) begin
            valid_ff[wa_c] <= 1'b1;
         end

         // Drop a result once it transfers; the done step loads the next one itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff  <= req_data.mode;
                  lit_ff <= 1'b0;
                  sel_ff <= 8'd0;
                  unique case (req_data.mode)
                     ssmc_pkg::MODE_TICK: begin
                        visible_ff   <= visible_in;
                        flash_ref_ff <= flash_ref_in;
                        pwm_ff       <= (pwm_ff == ssmc_pkg::PWM_LAST) ? 4'd0
                                                                       : pwm_ff + 4'd1;
                        if (lit_c) begin
                           lit_ff  <= 1'b1;
                           sel_ff  <= sel_c;
                           scan_ff <= scan_next_c;
                        end
                        state_ff <= S_DONE;
                     end
                     ssmc_pkg::MODE_NUMBER: begin
                        val_ff   <= req_data.number_value;
                        idx_ff   <= IDX_W'(n_c - CNT_W'(1));
                        state_ff <= S_DIV;
                     end
                     ssmc_pkg::MODE_ERROR, ssmc_pkg::MODE_CLEAR: begin
                        idx_ff   <= '0;
                        state_ff <= S_SWEEP;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_DIV: begin
               quot_ff  <= prod_c[63:35];
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               // Advance to the next digit to the left
               val_ff <= 32'(quot_ff);
               if (idx_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff - IDX_W'(1);
                  state_ff <= S_DIV;
               end
            end
            S_SWEEP: begin
               if (CNT_W'(idx_ff) + CNT_W'(1) == n_c) begin
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            S_DONE: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  latch_ff                  <= latch_in;
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.segment_lines <= latch_in;
                  rsp_data_ff.digit_select  <= sel_ff;
                  rsp_data_ff.digit_lit     <= lit_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: test/seven_segment_mux_controller_tb.sv
module seven_segment_mux_controller_tb;

   localparam int DIGITS_MAX    = ssmc_pkg::MAX_DIGITS_DEFAULT;
   localparam int PWM_STEPS     = 10;
   localparam int RESET_CYCLES  = 9;
   // longest command is a number write over all digits
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES        = 13;
   localparam int PHASE_ITEMS   = 100;
   localparam int PRESSURE_PHASE = 5;
   localparam int LONG_HOLD     = 300;
   localparam logic [2:0] MODE_UNUSED_LO = ssmc_pkg::MODE_CLEAR + 3'd1;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
   // decimal glyphs, digit d at bits [8*d +: 8]
   localparam logic [79:0] DIGIT_GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                           8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ssmc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ssmc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [ssmc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ssmc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // display model state
   logic [7:0] glyph_store [DIGITS_MAX];
   int         scan_at = 0;
   int         pwm_step = 0;
   logic       flash_on = 1'b1;
   logic [31:0] flash_since = '0;
   logic [7:0] held_segments = '0;

   // register copy, reset values
   logic [3:0]  cfg_digit_count = 4'd4;
   logic [6:0]  cfg_brightness = ssmc_pkg::FULL_BRIGHT;
   logic        cfg_lead_zeros = 1'b0;
   logic [3:0]  cfg_point_pos = 4'd0;
   logic        cfg_enable = 1'b1;
   logic [15:0] cfg_flash_ms = 16'd0;

   ssmc_pkg::req_type command_queue[$];
   ssmc_pkg::rsp_type lines_due[$];
   logic [31:0] ms_now = 32'hFFFF_FF80;
   string char_glyphs = "0123456789HELPOACUStrbInd-";

   int send_gap_pct = 0;
   int send_gap_left = 0;
   int take_gap_pct = 0;
   int take_gap_left = 0;
   int stall_asks = 0;
   int stall_taken = 0;
   int hold_left = 0;
   int results_seen = 0;
   int mismatch_count = 0;

   initial begin
      for (int k = 0; k < DIGITS_MAX; k++) glyph_store[k] = ssmc_pkg::PAT_BLANK;
   end

   seven_segment_mux_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("seven_segment_mux_controller_tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   // Advance the display model by one command and return the line state it drives.
   function automatic ssmc_pkg::rsp_type predict_display(input ssmc_pkg::req_type cmd);
      ssmc_pkg::rsp_type r;
      int          n;
      int          k;
      int          d;
      logic [31:0] v;
      logic [31:0] elapsed;
      logic [7:0]  p;
      n = (cfg_digit_count == 4'd0) ? 1 :
          (cfg_digit_count > DIGITS_MAX) ? DIGITS_MAX : int'(cfg_digit_count);
      r.digit_select = 8'd0;
      r.digit_lit = 1'b0;
      case (cmd.mode)
         ssmc_pkg::MODE_TICK: begin
            // flash toggle first, then brightness gate, then scan
            if (cfg_flash_ms != 16'd0) begin
               elapsed = cmd.now_ms - flash_since;
               if (elapsed >= {16'd0, cfg_flash_ms}) begin
                  flash_since = cmd.now_ms;
                  flash_on = !flash_on;
               end
            end else begin
               flash_on = 1'b1;
               flash_since = cmd.now_ms;
            end
            if (cfg_enable && flash_on && pwm_step < int'(cfg_brightness) / 10) begin
               if (scan_at >= n) scan_at = 0;
               held_segments = glyph_store[scan_at];
               r.digit_select = 8'd1 << scan_at;
               r.digit_lit = 1'b1;
               scan_at = (scan_at + 1) % n;
            end
            pwm_step = (pwm_step + 1) % PWM_STEPS;
         end
         ssmc_pkg::MODE_NUMBER: begin
            // fill from the right; digits beyond the count are dropped
            v = cmd.number_value;
            for (k = n - 1; k >= 0; k--) begin
               d = int'(v % 32'd10);
               if (v == 32'd0 && k < n - 1 && !cfg_lead_zeros) p = ssmc_pkg::PAT_BLANK;
               else p = DIGIT_GLYPHS[d*8 +: 8];
               v = v / 32'd10;
               if (int'(cfg_point_pos) == n - k) p = p | ssmc_pkg::POINT_BIT;
               glyph_store[k] = p;
            end
         end
         ssmc_pkg::MODE_CHAR: begin
            if (int'(cmd.char_position) < n) begin
               if (cmd.char_code >= "0" && cmd.char_code <= "9") begin
                  p = DIGIT_GLYPHS[(cmd.char_code - "0")*8 +: 8];
               end else begin
                  case (cmd.char_code)
                     "H": p = 8'h76;
                     "E": p = 8'h79;
                     "L": p = 8'h38;
                     "P": p = 8'h73;
                     "O": p = 8'h3F;
                     "A": p = 8'h77;
                     "C": p = 8'h39;
                     "U": p = 8'h3E;
                     "S": p = 8'h6D;
                     "t": p = 8'h78;
                     "r": p = 8'h50;
                     "b": p = 8'h7C;
                     "I": p = 8'h06;
                     "n": p = 8'h54;
                     "d": p = 8'h5E;
                     "-": p = 8'h40;
                     default: p = ssmc_pkg::PAT_BLANK;
                  endcase
               end
               glyph_store[cmd.char_position] = p;
            end
         end
         ssmc_pkg::MODE_ERROR, ssmc_pkg::MODE_CLEAR: begin
            for (k = 0; k < n; k++) glyph_store[k] = ssmc_pkg::PAT_BLANK;
            if (cmd.mode == ssmc_pkg::MODE_ERROR && n >= 3) begin
               glyph_store[0] = ssmc_pkg::PAT_E;
               glyph_store[1] = ssmc_pkg::PAT_R;
               glyph_store[2] = ssmc_pkg::PAT_R;
            end
         end
         default: begin
         end
      endcase
      r.segment_lines = held_segments;
      return r;
   endfunction

   function automatic ssmc_pkg::req_type make_command(input logic [2:0] mode,
                                                      input logic [31:0] value,
                                                      input logic [7:0] code,
                                                      input logic [2:0] pos,
                                                      input logic [31:0] now);
      ssmc_pkg::req_type c;
      c.mode = mode;
      c.number_value = value;
      c.char_code = code;
      c.char_position = pos;
      c.now_ms = now;
      return c;
   endfunction

   // Random command, mostly refresh ticks on an advancing millisecond time.
   function automatic ssmc_pkg::req_type next_command();
      ssmc_pkg::req_type c;
      int      roll;
      c = make_command(ssmc_pkg::MODE_TICK, $urandom(), 8'($urandom_range(0, 255)),
                       3'($urandom_range(0, 7)), $urandom());
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         case ($urandom_range(0, 59))
            0: ms_now = $urandom();
            1: ms_now = ms_now + $urandom_range(60000, 70000);
            default: ms_now = ms_now + $urandom_range(0, 3);
         endcase
         c.now_ms = ms_now;
      end else if (roll < 70) begin
         c.mode = ssmc_pkg::MODE_NUMBER;
         case ($urandom_range(0, 3))
            0: c.number_value = $urandom_range(0, 9);
            1: c.number_value = $urandom_range(0, 9999);
            2: c.number_value = $urandom_range(0, 99999999);
            default: c.number_value = $urandom();
         endcase
      end else if (roll < 85) begin
         c.mode = ssmc_pkg::MODE_CHAR;
         if ($urandom_range(0, 1) == 0)
            c.char_code = char_glyphs[$urandom_range(0, char_glyphs.len() - 1)];
      end else if (roll < 90) begin
         c.mode = ssmc_pkg::MODE_ERROR;
      end else if (roll < 95) begin
         c.mode = ssmc_pkg::MODE_CLEAR;
      end else begin
         c.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      end
      return c;
   endfunction

   task automatic program_register(input logic [ssmc_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [ssmc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ssmc_pkg::CSR_DIGIT_COUNT: cfg_digit_count = value[3:0];
         ssmc_pkg::CSR_BRIGHTNESS:
            cfg_brightness = (value[6:0] > ssmc_pkg::FULL_BRIGHT) ? ssmc_pkg::FULL_BRIGHT
                                                                  : value[6:0];
         ssmc_pkg::CSR_LEAD_ZEROS:  cfg_lead_zeros = value[0];
         ssmc_pkg::CSR_POINT_POS:   cfg_point_pos = value[3:0];
         ssmc_pkg::CSR_DISP_ENABLE: cfg_enable = value[0];
         ssmc_pkg::CSR_FLASH_INTVL: cfg_flash_ms = value[15:0];
         default: begin
         end
      endcase
   endtask

   // Hold until every queued command is sent and answered, then let the block settle.
   task automatic wait_until_drained();
      while (command_queue.size() != 0 || req_valid || lines_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drive commands from the pending queue, with random gaps between transfers.
   always @(posedge clock) begin : send_commands
      logic valid_next;
      valid_next = req_valid;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lines_due.push_back(predict_display(req_data));
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
            end else if (command_queue.size() != 0) begin
               if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
                  send_gap_left = $urandom_range(0, 14);
               end else begin
                  req_data <= command_queue.pop_front();
                  valid_next = 1'b1;
               end
            end
         end
      end
      req_valid <= valid_next;
   end

   // Check each result transfer against the oldest prediction; stall at random.
   always @(posedge clock) begin : take_results
      logic    ready_next;
      ssmc_pkg::rsp_type want;
      ssmc_pkg::rsp_type got;
      ready_next = 1'b1;
      if (reset) begin
         ready_next = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (lines_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_seen));
            end else begin
               want = lines_due.pop_front();
               if (got.segment_lines !== want.segment_lines)
                  report_mismatch($sformatf("result %0d segment_lines: expected %02h, got %02h",
                                            results_seen, want.segment_lines,
                                            got.segment_lines));
               if (got.digit_select !== want.digit_select)
                  report_mismatch($sformatf("result %0d digit_select: expected %02h, got %02h",
                                            results_seen, want.digit_select,
                                            got.digit_select));
               if (got.digit_lit !== want.digit_lit)
                  report_mismatch($sformatf("result %0d digit_lit: expected %0b, got %0b",
                                            results_seen, want.digit_lit, got.digit_lit));
            end
            results_seen++;
         end
         if (stall_taken != stall_asks) begin
            hold_left = LONG_HOLD;
            stall_taken = stall_asks;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (take_gap_left > 0) begin
            take_gap_left--;
            ready_next = 1'b0;
         end else if (take_gap_pct != 0 && $urandom_range(0, 99) < take_gap_pct) begin
            take_gap_left = $urandom_range(0, 14);
            ready_next = 1'b0;
         end
      end
      rsp_ready <= ready_next;
   end

   initial begin : run_stimulus
      int          ph;
      int          i;
      logic [15:0] dc;
      logic [15:0] br;
      logic [15:0] lz;
      logic [15:0] pp;
      logic [15:0] en;
      logic [15:0] fi;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: blanking, dropped digits, char map edges, error and clear
      command_queue.push_back(make_command(ssmc_pkg::MODE_NUMBER, 32'd0, 8'd0, 3'd0, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd1));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd2));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0,
                                           32'hFFFF_FFFF));
      command_queue.push_back(make_command(ssmc_pkg::MODE_NUMBER, 32'hFFFF_FFFF, 8'hFF, 3'd7,
                                           32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd5));
      command_queue.push_back(make_command(ssmc_pkg::MODE_CHAR, 32'd0, "-", 3'd0, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_CHAR, 32'd0, 8'hFF, 3'd1, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_CHAR, 32'd0, "H", 3'd7, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_CHAR, 32'd0, "0", 3'd3, 32'd0));
      for (i = 0; i < 4; i++)
         command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0,
                                              32'd6 + i));
      command_queue.push_back(make_command(ssmc_pkg::MODE_ERROR, 32'd0, 8'd0, 3'd0, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd10));
      command_queue.push_back(make_command(ssmc_pkg::MODE_CLEAR, 32'd0, 8'd0, 3'd0, 32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd11));
      command_queue.push_back(make_command(MODE_UNUSED_HI, $urandom(), 8'hA5, 3'd5,
                                           $urandom()));
      command_queue.push_back(make_command(ssmc_pkg::MODE_NUMBER, 32'd1234, 8'd0, 3'd0,
                                           32'd0));
      command_queue.push_back(make_command(ssmc_pkg::MODE_TICK, 32'd0, 8'd0, 3'd0, 32'd12));

      for (ph = 0; ph < PHASES; ph++) begin
         wait_until_drained();
         // first phases hit the register extremes, the rest are random
         case (ph)
            0: begin dc = 16'd8;  br = 16'd100; lz = 16'd1; pp = 16'd8;  en = 16'd1; fi = 16'd0; end
            1: begin dc = 16'd1;  br = 16'd127; lz = 16'd0; pp = 16'd1;  en = 16'd1; fi = 16'd1; end
            2: begin dc = 16'd0;  br = 16'd0;   lz = 16'd1; pp = 16'd0;  en = 16'd0; fi = 16'hFFFF; end
            3: begin dc = 16'd15; br = 16'd100; lz = 16'd0; pp = 16'd15; en = 16'd1; fi = 16'd3; end
            default: begin
               dc = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 8))
                                                  : 16'($urandom_range(0, 15));
               br = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(60, 127))
                                                : 16'($urandom_range(0, 127));
               lz = 16'($urandom_range(0, 1));
               pp = 16'($urandom_range(0, 15));
               en = ($urandom_range(0, 99) < 85) ? 16'd1 : 16'd0;
               case ($urandom_range(0, 2))
                  0: fi = 16'd0;
                  1: fi = 16'($urandom_range(1, 8));
                  default: fi = 16'($urandom());
               endcase
            end
         endcase
         program_register(ssmc_pkg::CSR_DIGIT_COUNT, dc);
         program_register(ssmc_pkg::CSR_BRIGHTNESS, br);
         program_register(ssmc_pkg::CSR_LEAD_ZEROS, lz);
         program_register(ssmc_pkg::CSR_POINT_POS, pp);
         program_register(ssmc_pkg::CSR_DISP_ENABLE, en);
         program_register(ssmc_pkg::CSR_FLASH_INTVL, fi);

         // pick idling for this phase; pressure phase backs up the block
         if (ph == PRESSURE_PHASE) begin
            send_gap_pct <= 0;
            take_gap_pct <= 0;
            stall_asks <= stall_asks + 1;
         end else if (ph == PHASES - 1) begin
            send_gap_pct <= 0;
            take_gap_pct <= 0;
         end else begin
            send_gap_pct <= $urandom_range(0, 2) * 15;
            take_gap_pct <= $urandom_range(0, 2) * 15;
         end
         for (i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(next_command());
      end

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("seven_segment_mux_controller_tb OK");
      end else begin
         $display("seven_segment_mux_controller_tb NOT OK");
      end
      $finish;
   end

endmodule
